[hdl/ghbs_pkg.sv]
// shared types and constants for the gcr head bit shifter
package ghbs_pkg;

  // ring index width and sync run length
  localparam int PositionWidth = 16;
  localparam int SyncOnes      = 10;

  // bit-cell timing and byte framing
  localparam logic [4:0]  CELL_STEP   = 5'd16;
  localparam logic [7:0]  MIN_DIVISOR = 8'd17;
  localparam logic [3:0]  FRAME_BITS  = 4'd8;
  localparam logic [7:0]  LAST_BYTE_RESET = 8'hFF;
  localparam logic [3:0]  SYNC_ONES_COUNT = 4'(SyncOnes);

  // one drive cycle worth of inputs
  typedef struct packed {
    logic                     disk_in;
    logic                     spindle_on;
    logic                     head_write;
    logic [PositionWidth-1:0] track_bits;
    logic [7:0]               cell_divisor;
    logic                     surface_bit;
    logic [7:0]               write_value;
  } item_t;

  // one drive cycle worth of results
  typedef struct packed {
    logic                     byte_done;
    logic [7:0]               assembled_byte;
    logic                     sync_mark;
    logic [PositionWidth-1:0] head_position;
    logic                     write_strobe;
    logic [PositionWidth-1:0] write_start;
    logic [7:0]               write_byte;
  } result_t;

endpackage

[hdl/gcr_head_bit_shifter_unit.sv]
// gcr head bit shifter: cell timing, head position, sync detect and byte framing
//
//   channel  direction  handshake                   payload
//   item     in         item_valid / item_stall     item   (ghbs_pkg::item_t)
//   result   out        result_valid / result_stall result (ghbs_pkg::result_t)
//
// one item per clock while the result side does not stall; an item passes through two
// registers: the input register, then the result register after a single pass of the update logic
// the drive state (accumulator, position, shifter, counters) updates as an item
// moves from the input register to the result register
// rst clears both registers and sets the drive state to its power-up values
// a stalled result holds; the input register keeps taking transfers while the
// result register is free or is being drained in the same cycle
module gcr_head_bit_shifter_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  ghbs_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output ghbs_pkg::result_t result
);
  import ghbs_pkg::*;

  // input register
  logic  held_valid;
  item_t held;

  // drive state
  logic [8:0]               cell_accumulator;
  logic [PositionWidth-1:0] bit_position;
  logic [7:0]               shift_bits;
  logic [3:0]               ones_count;
  logic [3:0]               frame_count;
  logic                     in_sync;
  logic [7:0]               last_byte;
  logic                     was_writing;

  logic [8:0]               cell_accumulator_next;
  logic [PositionWidth-1:0] bit_position_next;
  logic [7:0]               shift_bits_next;
  logic [3:0]               ones_count_next;
  logic [3:0]               frame_count_next;
  logic                     in_sync_next;
  logic [7:0]               last_byte_next;
  logic                     was_writing_next;
  result_t                  result_next;

  logic advance;

  // pipeline flow
  assign advance    = held_valid && (!result_valid || !result_stall);
  assign item_stall = held_valid && !advance;

  // one pass of the drive update for the held item
  always_comb begin
    logic                     idle;
    logic [7:0]               div;
    logic [9:0]               acc_sum;
    logic                     cell_step;
    logic [PositionWidth-1:0] pos_inc;
    logic [PositionWidth:0]   wrap_sum;
    logic [3:0]               fc;

    cell_accumulator_next = cell_accumulator;
    bit_position_next     = bit_position;
    shift_bits_next       = shift_bits;
    ones_count_next       = ones_count;
    frame_count_next      = frame_count;
    in_sync_next          = in_sync;
    last_byte_next        = last_byte;
    was_writing_next      = was_writing;

    result_next.byte_done    = 1'b0;
    result_next.write_strobe = 1'b0;
    result_next.write_start  = '0;
    result_next.write_byte   = '0;

    idle = !held.disk_in || !held.spindle_on ||
           (held.track_bits < PositionWidth'(FRAME_BITS));
    div  = (held.cell_divisor < MIN_DIVISOR) ? MIN_DIVISOR : held.cell_divisor;
    acc_sum   = {1'b0, cell_accumulator} + 10'(CELL_STEP);
    cell_step = acc_sum >= {2'b00, div};
    pos_inc   = bit_position + PositionWidth'(1);
    fc        = frame_count;
    wrap_sum  = '0;

    if (idle) begin
      in_sync_next     = 1'b0;
      was_writing_next = 1'b0;
    end else begin
      // write entry restarts framing
      if (held.head_write && !was_writing) begin
        fc = '0;
      end
      was_writing_next = held.head_write;
      cell_accumulator_next = cell_step ? 9'(acc_sum - {2'b00, div}) : 9'(acc_sum);

      if (cell_step) begin
        // advance head around the ring
        bit_position_next = (pos_inc >= held.track_bits) ? '0 : pos_inc;

        if (held.head_write) begin
          // write: frame bytes and strobe the start index
          in_sync_next    = 1'b0;
          ones_count_next = '0;
          fc = fc + 4'd1;
          if (fc >= FRAME_BITS) begin
            fc = '0;
            wrap_sum = {1'b0, bit_position_next} + {1'b0, held.track_bits}
                       - (PositionWidth+1)'(FRAME_BITS);
            result_next.write_start =
              (bit_position_next >= PositionWidth'(FRAME_BITS)) ?
              bit_position_next - PositionWidth'(FRAME_BITS) :
              wrap_sum[PositionWidth-1:0];
            result_next.write_byte   = held.write_value;
            result_next.write_strobe = 1'b1;
            result_next.byte_done    = 1'b1;
          end
        end else begin
          // read: shift surface bit, track ones run
          shift_bits_next = {shift_bits[6:0], held.surface_bit};
          if (held.surface_bit) begin
            if (ones_count < SYNC_ONES_COUNT) begin
              ones_count_next = ones_count + 4'd1;
            end
          end else begin
            ones_count_next = '0;
          end
          if (ones_count_next >= SYNC_ONES_COUNT) begin
            in_sync_next = 1'b1;
            fc = '0;
          end else begin
            if (in_sync) begin
              in_sync_next = 1'b0;
              fc = 4'd1;
            end else begin
              fc = fc + 4'd1;
            end
            if (fc >= FRAME_BITS) begin
              fc = '0;
              last_byte_next = shift_bits_next;
              result_next.byte_done = 1'b1;
            end
          end
        end
      end
      frame_count_next = fc;
    end

    result_next.assembled_byte = last_byte_next;
    result_next.sync_mark      = in_sync_next;
    result_next.head_position  = bit_position_next;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
    if (!item_stall && item_valid) begin
      held <= item;
    end
  end

  // drive state update
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_accumulator <= '0;
      bit_position     <= '0;
      shift_bits       <= '0;
      ones_count       <= '0;
      frame_count      <= '0;
      in_sync          <= 1'b0;
      last_byte        <= LAST_BYTE_RESET;
      was_writing      <= 1'b0;
    end else if (advance) begin
      cell_accumulator <= cell_accumulator_next;
      bit_position     <= bit_position_next;
      shift_bits       <= shift_bits_next;
      ones_count       <= ones_count_next;
      frame_count      <= frame_count_next;
      in_sync          <= in_sync_next;
      last_byte        <= last_byte_next;
      was_writing      <= was_writing_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

[tb/gcr_head_bit_shifter_checker.sv]
// result checker for the gcr head bit shifter: drive state prediction and comparison
`timescale 1ns / 1ps

module gcr_head_bit_shifter_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  ghbs_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  ghbs_pkg::result_t result,
  output int                mismatches,
  output int                outstanding
);

  import ghbs_pkg::*;

  // predicted drive state
  logic [8:0]  cell_acc;
  logic [15:0] head_pos;
  logic [7:0]  shift_reg;
  logic [3:0]  ones_len;
  logic [3:0]  frame_cnt;
  logic        sync_on;
  logic [7:0]  held_byte;
  logic        writing_prev;

  // results owed by the block, oldest first
  result_t expected_results[$];
  result_t next_result;
  result_t oldest;

  // one drive cycle: bit-cell timing, head movement, sync and byte framing
  task automatic drive_cycle(input item_t it, output result_t res);
    logic [7:0]  cell_len;
    logic [9:0]  acc_sum;
    logic [16:0] start_sum;
    res = '0;
    if (!it.disk_in || !it.spindle_on || it.track_bits < 16'(FRAME_BITS)) begin
      // idle drive or no track
      sync_on      = 1'b0;
      writing_prev = 1'b0;
    end else begin
      // entering write mode restarts the byte framing
      if (it.head_write && !writing_prev) frame_cnt = '0;
      writing_prev = it.head_write;
      cell_len = (it.cell_divisor < MIN_DIVISOR) ? MIN_DIVISOR : it.cell_divisor;
      acc_sum  = cell_acc + CELL_STEP;
      if (acc_sum >= 10'(cell_len)) begin
        acc_sum  = acc_sum - 10'(cell_len);
        head_pos = head_pos + 16'd1;
        // wrap at or past the ring end
        if (head_pos >= it.track_bits) head_pos = '0;
        if (it.head_write) begin
          sync_on   = 1'b0;
          ones_len  = '0;
          frame_cnt = frame_cnt + 4'd1;
          if (frame_cnt >= FRAME_BITS) begin
            frame_cnt = '0;
            start_sum = (head_pos >= 16'(FRAME_BITS))
                        ? 17'(head_pos) - 17'(FRAME_BITS)
                        : 17'(head_pos) + 17'(it.track_bits) - 17'(FRAME_BITS);
            res.write_strobe = 1'b1;
            res.write_start  = start_sum[15:0];
            res.write_byte   = it.write_value;
            res.byte_done    = 1'b1;
          end
        end else begin
          shift_reg = {shift_reg[6:0], it.surface_bit};
          // ones run saturates at the sync length
          if (it.surface_bit) begin
            if (ones_len < SYNC_ONES_COUNT) ones_len = ones_len + 4'd1;
          end else begin
            ones_len = '0;
          end
          if (ones_len >= SYNC_ONES_COUNT) begin
            sync_on   = 1'b1;
            frame_cnt = '0;
          end else begin
            // the first cell after sync counts as the first framed bit
            if (sync_on) begin
              sync_on   = 1'b0;
              frame_cnt = 4'd1;
            end else begin
              frame_cnt = frame_cnt + 4'd1;
            end
            if (frame_cnt >= FRAME_BITS) begin
              frame_cnt     = '0;
              held_byte     = shift_reg;
              res.byte_done = 1'b1;
            end
          end
        end
      end
      cell_acc = acc_sum[8:0];
    end
    res.assembled_byte = held_byte;
    res.sync_mark      = sync_on;
    res.head_position  = head_pos;
  endtask

  function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endfunction

  // compare each result transfer with the oldest prediction, then predict new items
  always @(posedge clk) begin
    if (rst) begin
      cell_acc     = '0;
      head_pos     = '0;
      shift_reg    = '0;
      ones_len     = '0;
      frame_cnt    = '0;
      sync_on      = 1'b0;
      held_byte    = LAST_BYTE_RESET;
      writing_prev = 1'b0;
      mismatches   = 0;
      expected_results.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, expected none, got %h", $time, result);
        end else begin
          oldest = expected_results.pop_front();
          check_field("byte_done", 16'(oldest.byte_done), 16'(result.byte_done));
          check_field("assembled_byte", 16'(oldest.assembled_byte),
                      16'(result.assembled_byte));
          check_field("sync_mark", 16'(oldest.sync_mark), 16'(result.sync_mark));
          check_field("head_position", oldest.head_position, result.head_position);
          check_field("write_strobe", 16'(oldest.write_strobe), 16'(result.write_strobe));
          check_field("write_start", oldest.write_start, result.write_start);
          check_field("write_byte", 16'(oldest.write_byte), 16'(result.write_byte));
        end
      end
      if (item_valid && !item_stall) begin
        drive_cycle(item, next_result);
        expected_results.push_back(next_result);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

[tb/tb_gcr_head_bit_shifter_unit.sv]
// testbench top for the gcr head bit shifter: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_gcr_head_bit_shifter_unit;

  import ghbs_pkg::*;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_stall;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  int mismatches;
  int outstanding;
  int send_idle_pct = 17;
  int stall_pct     = 62;
  int items_sent    = 0;

  gcr_head_bit_shifter_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  gcr_head_bit_shifter_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // 2 ns clock
  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #200000;
    $display("Verification failed");
    $finish;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    result_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  function automatic item_t make_item(bit disk, bit motor, bit wmode, logic [15:0] track,
                                      logic [7:0] cell_div, bit sbit, logic [7:0] wval);
    item_t it;
    it.disk_in      = disk;
    it.spindle_on   = motor;
    it.head_write   = wmode;
    it.track_bits   = track;
    it.cell_divisor = cell_div;
    it.surface_bit  = sbit;
    it.write_value  = wval;
    return it;
  endfunction

  // one item transfer, after a random gap; stall is sampled on the falling edge
  task automatic send_item(input item_t it);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !item_stall;
      @(posedge clk);
    end
    items_sent++;
  endtask

  // random drive traffic, mostly sync runs followed by gcr bytes
  task automatic run_phase(input int sender_pct, input int receiver_pct, input int quota);
    int          target;
    int          kind;
    logic [15:0] track;
    logic [7:0]  div_len;
    logic [7:0]  pattern;
    bit          disk;
    send_idle_pct = sender_pct;
    stall_pct     = receiver_pct;
    target        = items_sent + quota;
    while (items_sent < target) begin
      kind    = $urandom_range(99);
      // small rings wrap often, short cells keep the head moving
      track   = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(200, 8));
      div_len = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(20, 15));
      if (kind < 65) begin
        // ones run, sometimes too short for sync, then framed bytes
        repeat ($urandom_range(16, 8))
          send_item(make_item(1'b1, 1'b1, 1'b0, track, div_len, 1'b1, 8'($urandom)));
        repeat ($urandom_range(5, 1)) begin
          pattern = 8'($urandom);
          for (int b = 7; b >= 0; b--)
            send_item(make_item(1'b1, 1'b1, 1'b0, track, div_len, pattern[b],
                                8'($urandom)));
        end
      end else if (kind < 85) begin
        // write burst
        repeat ($urandom_range(40, 6))
          send_item(make_item(1'b1, 1'b1, 1'b1, track, div_len, 1'($urandom),
                              8'($urandom)));
      end else if (kind < 95) begin
        // unstructured noise, no-track lengths included
        repeat ($urandom_range(12, 1))
          send_item(make_item(1'($urandom), 1'($urandom), 1'($urandom),
                              $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(15)),
                              8'($urandom), 1'($urandom), 8'($urandom)));
      end else begin
        // disk out or motor off
        repeat ($urandom_range(4, 1)) begin
          disk = 1'($urandom);
          send_item(make_item(disk, !disk, 1'($urandom), track, div_len, 1'($urandom),
                              8'($urandom)));
        end
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // idle drive and no track
    send_item(make_item(1'b0, 1'b1, 1'b0, 16'd100, 8'd17, 1'b1, 8'h00));
    send_item(make_item(1'b1, 1'b0, 1'b0, 16'd100, 8'd17, 1'b1, 8'h00));
    send_item(make_item(1'b1, 1'b1, 1'b0, 16'd0, 8'd17, 1'b1, 8'h00));
    send_item(make_item(1'b1, 1'b1, 1'b0, 16'd7, 8'd17, 1'b1, 8'h00));
    // short divisors on the smallest ring, long enough a ones run for sync
    for (int i = 0; i < 12; i++)
      send_item(make_item(1'b1, 1'b1, 1'b0, 16'd8, i[0] ? 8'd0 : 8'd16, 1'b1, 8'h00));
    // write entry straight out of sync on the longest ring, byte extremes
    for (int i = 0; i < 9; i++)
      send_item(make_item(1'b1, 1'b1, 1'b1, 16'hFFFF, 8'd17, 1'b0, i[0] ? 8'hFF : 8'h00));
    // longest bit cell
    send_item(make_item(1'b1, 1'b1, 1'b0, 16'hFFFF, 8'hFF, 1'b0, 8'h00));

    run_phase(17, 62, 430);
    run_phase(62, 17, 430);
    run_phase(0, 0, 440);

    item_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/ghbs_pkg.sv
hdl/gcr_head_bit_shifter_unit.sv
tb/gcr_head_bit_shifter_checker.sv
tb/tb_gcr_head_bit_shifter_unit.sv
